/* rtl/core/mpi_pkg.sv */
// mpi_pkg: shared widths, controller states, datapath commands and status
// for the mountain range proof index block; no dependencies
`default_nettype none

package mpi_pkg;

  // fixed field widths
  localparam int DATA_W    = 64;
  localparam int EXTRA_W   = 3;
  // bits of the proof word that can hold a slot
  localparam int WORD_BITS = 64;
  // slot counter: up to 7 + 70 steps of 8 slots stays below 1024
  localparam int SLOT_W    = 10;
  localparam int STRIDE_W  = EXTRA_W + 1;
  // counts of set bits in a 64-bit size, 0..64
  localparam int CNT_W     = 7;
  localparam int IDX_W     = $clog2(WORD_BITS);

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_SCAN,
    ST_TREE,
    ST_DONE
  } mpi_state_t;

  // datapath commands
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLIMB,
    OP_PEAK,
    OP_SCAN,
    OP_TREE,
    OP_EMIT
  } mpi_op_t;

  // datapath status seen by the controller
  typedef struct packed {
    logic layer_end;
    logic at_peak;
    logic scan_last;
    logic tree_end;
  } mpi_status_t;

endpackage

`default_nettype wire

/* rtl/core/mpi_datapath.sv */
// mpi_datapath: layer walk, peak count scan and peak tree walk registers
// depends on mpi_pkg; driven by mpi_ctrl through mpi_op_t commands
`default_nettype none

module mpi_datapath (
  input  wire logic                         clk,
  input  wire logic [mpi_pkg::DATA_W-1:0]   in_position,
  input  wire logic [mpi_pkg::DATA_W-1:0]   in_view_size,
  input  wire logic [mpi_pkg::EXTRA_W-1:0]  in_extra_hashes,
  input  wire mpi_pkg::mpi_op_t             op,
  output mpi_pkg::mpi_status_t              status,
  output logic [mpi_pkg::DATA_W-1:0]        out_proof_index
);
  import mpi_pkg::*;

  logic [DATA_W-1:0]   p_r, p_nxt;
  logic [DATA_W-1:0]   lsize_r, lsize_nxt;
  logic [DATA_W-1:0]   ret_r, ret_nxt;
  logic [DATA_W-1:0]   out_r, out_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [STRIDE_W-1:0] stride_r, stride_nxt;
  logic [CNT_W-1:0]    below_r, below_nxt;
  logic [CNT_W-1:0]    q_r, q_nxt;
  logic [CNT_W-1:0]    s_r, s_nxt;
  logic                triv_r, triv_nxt;

  logic [DATA_W-1:0]   slot_mask;
  logic [SLOT_W-1:0]   slot_adv;
  logic                has_right;
  logic [3:0]          pop_lo;
  logic [CNT_W-1:0]    q_sum;
  logic                tree_take;

  // count of set bits in one byte
  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] c;
    c = '0;
    for (int i = 0; i < 8; i++) begin
      c = c + {3'b000, v[i]};
    end
    return c;
  endfunction

  // one-hot slot bit, dropped once the slot runs past the word
  assign slot_mask = (slot_r < SLOT_W'(WORD_BITS)) ?
                     (DATA_W'(1) << slot_r[IDX_W-1:0]) : '0;
  assign slot_adv  = slot_r + SLOT_W'(stride_r);

  // even node still has a right neighbour in its layer
  assign has_right = {1'b0, lsize_r} > ({1'b0, p_r} + 65'd1);

  // peak index scan, one byte of the upper size bits a cycle
  assign pop_lo = pop8(lsize_r[7:0]);
  assign q_sum  = q_r + CNT_W'(pop_lo);

  // peak tree level takes a slot unless the node passes through
  assign tree_take = (q_r < (s_r - CNT_W'(1))) || q_r[0];

  assign status.layer_end = triv_r || (lsize_r == '0);
  assign status.at_peak   = !p_r[0] && !has_right;
  assign status.scan_last = (lsize_r[DATA_W-1:8] == '0);
  assign status.tree_end  = (s_r <= CNT_W'(1));

  // next values per command
  always_comb begin
    p_nxt      = p_r;
    lsize_nxt  = lsize_r;
    ret_nxt    = ret_r;
    out_nxt    = out_r;
    slot_nxt   = slot_r;
    stride_nxt = stride_r;
    below_nxt  = below_r;
    q_nxt      = q_r;
    s_nxt      = s_r;
    triv_nxt   = triv_r;
    case (op)
      OP_LOAD: begin
        p_nxt      = in_position;
        lsize_nxt  = in_view_size;
        ret_nxt    = '0;
        slot_nxt   = SLOT_W'(in_extra_hashes);
        stride_nxt = STRIDE_W'(in_extra_hashes) + STRIDE_W'(1);
        below_nxt  = '0;
        q_nxt      = '0;
        s_nxt      = '0;
        triv_nxt   = (in_position == '0) || (in_position >= in_view_size);
      end
      OP_CLIMB: begin
        if (p_r[0]) begin
          ret_nxt = ret_r | slot_mask;
        end
        slot_nxt  = slot_adv;
        p_nxt     = p_r >> 1;
        lsize_nxt = lsize_r >> 1;
        below_nxt = below_r + CNT_W'(lsize_r[0]);
      end
      OP_PEAK: begin
        below_nxt = below_r + CNT_W'(lsize_r[0]);
        lsize_nxt = lsize_r >> 1;
        q_nxt     = '0;
      end
      OP_SCAN: begin
        q_nxt     = q_sum;
        lsize_nxt = lsize_r >> 8;
        s_nxt     = below_r + q_sum;
      end
      OP_TREE: begin
        if (tree_take) begin
          if (q_r[0]) begin
            ret_nxt = ret_r | slot_mask;
          end
          slot_nxt = slot_adv;
        end
        q_nxt = q_r >> 1;
        s_nxt = (s_r >> 1) + CNT_W'(s_r[0]);
      end
      OP_EMIT: begin
        out_nxt = ret_r;
      end
      default: begin
      end
    endcase
  end

  // payload registers
  always_ff @(posedge clk) begin
    p_r      <= p_nxt;
    lsize_r  <= lsize_nxt;
    ret_r    <= ret_nxt;
    out_r    <= out_nxt;
    slot_r   <= slot_nxt;
    stride_r <= stride_nxt;
    below_r  <= below_nxt;
    q_r      <= q_nxt;
    s_r      <= s_nxt;
    triv_r   <= triv_nxt;
  end

  assign out_proof_index = out_r;

endmodule

`default_nettype wire

/* rtl/core/mpi_ctrl.sv */
// mpi_ctrl: state machine that sequences the datapath and owns both handshakes
// depends on mpi_pkg
`default_nettype none

module mpi_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  input  wire mpi_pkg::mpi_status_t status,
  output mpi_pkg::mpi_op_t          op
);
  import mpi_pkg::*;

  mpi_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // state and output valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    op            = OP_NONE;
    out_valid_nxt = out_valid_r && out_stall;
    in_stall      = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op        = OP_LOAD;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (status.layer_end) begin
          state_nxt = ST_DONE;
        end else if (status.at_peak) begin
          op        = OP_PEAK;
          state_nxt = ST_SCAN;
        end else begin
          op = OP_CLIMB;
        end
      end
      ST_SCAN: begin
        op = OP_SCAN;
        if (status.scan_last) begin
          state_nxt = ST_TREE;
        end
      end
      ST_TREE: begin
        if (status.tree_end) begin
          state_nxt = ST_DONE;
        end else begin
          op = OP_TREE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          op            = OP_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* rtl/core/mmr_proof_index.sv */
// mmr_proof_index: top level, joins the controller and the datapath
// depends on mpi_pkg, mpi_ctrl and mpi_datapath
`default_nettype none

// Computes the proof-direction word for one leaf of a mountain range view:
// one bit slot per proof step (set when the sibling is on the left), each
// step followed by extra_hashes skipped slots, walking up the layers and then
// through the tree of peaks. One transaction is worked on at a time. An item
// climbs one layer per step (up to 64 layers); on reaching a peak it counts
// the peak index from the remaining size bits a byte at a time and then walks
// the peak tree one level per step (up to 6 levels). A position of zero or not
// below the view size goes straight to the result. The layer walk runs one
// layer per cycle through the shared datapath. The result sits in an output
// register, so a new input is taken while it waits.
module mmr_proof_index (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [mpi_pkg::DATA_W-1:0]   in_position,
  input  wire logic [mpi_pkg::DATA_W-1:0]   in_view_size,
  input  wire logic [mpi_pkg::EXTRA_W-1:0]  in_extra_hashes,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [mpi_pkg::DATA_W-1:0]        out_proof_index
);
  import mpi_pkg::*;

  mpi_op_t     op;
  mpi_status_t status;

  // sequencer
  mpi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .op        (op)
  );

  // walk registers and output register
  mpi_datapath u_datapath (
    .clk             (clk),
    .in_position     (in_position),
    .in_view_size    (in_view_size),
    .in_extra_hashes (in_extra_hashes),
    .op              (op),
    .status          (status),
    .out_proof_index (out_proof_index)
  );

endmodule

`default_nettype wire

/* rtl/core/mpi_checker.sv */
// mpi_checker: port-level assertions for mmr_proof_index, bound to the top
// depends on mpi_pkg for the field widths
`default_nettype none

module mpi_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [mpi_pkg::DATA_W-1:0]  out_proof_index
);
  import mpi_pkg::*;

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_r, pend_nxt;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // transactions accepted but not yet delivered
  always_comb begin
    pend_nxt = pend_r + {1'b0, in_acc} - {1'b0, out_acc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // stalled result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // stalled result does not change
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_proof_index))
    else $error("result changed while stalled");

  // one item worked on at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("input taken while an item is at work");

  // no result without an accepted item
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result with no pending transaction");

  // at most one at work and one waiting
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("too many transactions in flight");

endmodule

bind mmr_proof_index mpi_checker u_mpi_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_proof_index (out_proof_index)
);

`default_nettype wire
